// ===== rtl/cphh_pkg.sv =====
// ----------------------------------------------------------------------------
// cphh_pkg: shared types and constants of the cascade heater controller
// Fixed-point widths, register indexes, tick codes and the structs passed
// between the configuration bank and the control datapath.
// ----------------------------------------------------------------------------
package cphh_pkg;

    // Fixed-point format of the gains and width of the error accumulator
    localparam int FRAC_BITS = 8;
    localparam int SUM_WIDTH = 32;

    // Field widths
    localparam int TEMP_W  = 16;   // signed Q8.8 sample
    localparam int TGT_W   = 15;   // unsigned Q7.8 setpoints and limits
    localparam int GAIN_W  = 16;
    localparam int DRIVE_W = 10;
    localparam int ERR_W   = 18;   // app_target - sample, and its first difference

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stream payload widths, tdata in whole bytes
    localparam int IN_TDATA_W  = 24;  // sample_temp, running
    localparam int IN_TUSER_W  = 1;   // opcode
    localparam int OUT_TDATA_W = 32;  // heater_target_out, heater_drive_out

    // Register reset values
    localparam logic [TGT_W-1:0]   APP_TARGET_RST  = TGT_W'(9600);
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = GAIN_W'(2560);
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = GAIN_W'(64);
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = GAIN_W'(256);
    localparam logic [TGT_W-1:0]   OUTER_LIMIT_RST = TGT_W'(20480);
    localparam logic [DRIVE_W-1:0] DRIVE_LIMIT_RST = DRIVE_W'(800);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_APP_TARGET  = 3'd0,
        CFG_PROP_GAIN   = 3'd1,
        CFG_INTEG_GAIN  = 3'd2,
        CFG_DERIV_GAIN  = 3'd3,
        CFG_OUTER_LIMIT = 3'd4,
        CFG_DRIVE_LIMIT = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_OUTER = 1'b0,
        OP_INNER = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [TGT_W-1:0]   app_target;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain_period;
        logic [GAIN_W-1:0]  deriv_gain_over_period;
        logic [TGT_W-1:0]   outer_limit;
        logic [DRIVE_W-1:0] drive_limit;
    } cfg_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic signed [TEMP_W-1:0] sample_temp;
        logic                     running;
    } item_t;

    typedef struct packed {
        logic [TGT_W-1:0]   heater_target;
        logic [DRIVE_W-1:0] heater_drive;
    } res_t;

endpackage

// ===== rtl/cphh_cfg.sv =====
// ----------------------------------------------------------------------------
// cphh_cfg: configuration register bank
// Holds the six control registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cphh_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cphh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cphh_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cphh_pkg::cfg_t                    cfg
);
    import cphh_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_APP_TARGET:  cfg_next.app_target             = cfg_data[TGT_W-1:0];
                CFG_PROP_GAIN:   cfg_next.prop_gain              = cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  cfg_next.integ_gain_period      = cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  cfg_next.deriv_gain_over_period = cfg_data[GAIN_W-1:0];
                CFG_OUTER_LIMIT: cfg_next.outer_limit            = cfg_data[TGT_W-1:0];
                CFG_DRIVE_LIMIT: cfg_next.drive_limit            = cfg_data[DRIVE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.app_target             <= APP_TARGET_RST;
            cfg_reg.prop_gain              <= PROP_GAIN_RST;
            cfg_reg.integ_gain_period      <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain_over_period <= DERIV_GAIN_RST;
            cfg_reg.outer_limit            <= OUTER_LIMIT_RST;
            cfg_reg.drive_limit            <= DRIVE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/cphh_pid.sv =====
// ----------------------------------------------------------------------------
// cphh_pid: control datapath and loop state
// Outer tick: PID step with clamping anti-windup. Inner tick: bang-bang drive.
// State advances on step; res_next is the state after this item.
// ----------------------------------------------------------------------------
module cphh_pid
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  cphh_pkg::item_t item,
    input  cphh_pkg::cfg_t  cfg,
    output cphh_pkg::res_t  res_next
);
    import cphh_pkg::*;

    localparam int TERM_W = ERR_W + GAIN_W + 1;            // gain x error product
    localparam int PROD_W = SUM_WIDTH + GAIN_W + 1;        // gain x error sum product
    localparam int TOT_W  = ((PROD_W > 63) ? PROD_W : 63) + 1;
    localparam logic signed [TOT_W-1:0] TERM_CAP = signed'(TOT_W'(1) << 61);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = signed'({1'b0, {(SUM_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = signed'({1'b1, {(SUM_WIDTH-1){1'b0}}});

    logic signed [SUM_WIDTH-1:0] error_sum_reg,     error_sum_next;
    logic signed [ERR_W-1:0]     last_error_reg,    last_error_next;
    logic [TGT_W-1:0]            heater_target_reg, heater_target_next;
    logic [DRIVE_W-1:0]          heater_drive_reg,  heater_drive_next;

    logic signed [ERR_W-1:0]     err;
    logic signed [ERR_W-1:0]     diff;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [PROD_W-1:0]    iterm_raw;
    logic signed [TOT_W-1:0]     iterm_ext;
    logic signed [TOT_W-1:0]     iterm;
    logic signed [TERM_W-1:0]    pterm;
    logic signed [TERM_W-1:0]    dterm;
    logic signed [TOT_W-1:0]     total;
    logic [TOT_W-1:0]            outv;
    logic                        over;
    logic                        hot;

    // Error terms
    assign err  = signed'({{(ERR_W-TGT_W){1'b0}}, cfg.app_target})
                - signed'({{(ERR_W-TEMP_W){item.sample_temp[TEMP_W-1]}}, item.sample_temp});
    assign diff = err - last_error_reg;

    // Saturating accumulate
    assign sum_wide = signed'({error_sum_reg[SUM_WIDTH-1], error_sum_reg})
                    + signed'({{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err});

    always_comb
    begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
            sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_wide[SUM_WIDTH-1:0];
    end

    // Three gain products, integral one capped at +-2^61
    assign iterm_raw = PROD_W'(signed'({1'b0, cfg.integ_gain_period})) * PROD_W'(sum_sat);
    assign pterm     = TERM_W'(signed'({1'b0, cfg.prop_gain})) * TERM_W'(err);
    assign dterm     = TERM_W'(signed'({1'b0, cfg.deriv_gain_over_period})) * TERM_W'(diff);
    assign iterm_ext = TOT_W'(iterm_raw);

    always_comb
    begin
        priority if (iterm_ext > TERM_CAP)
            iterm = TERM_CAP;
        else if (iterm_ext < -TERM_CAP)
            iterm = -TERM_CAP;
        else
            iterm = iterm_ext;
    end

    assign total = iterm + TOT_W'(pterm) + TOT_W'(dterm);
    assign outv  = unsigned'(total) >> FRAC_BITS;
    assign over  = outv > TOT_W'(cfg.outer_limit);

    // Heater sample below the target turns heating on
    assign hot = signed'({1'b0, heater_target_reg}) > item.sample_temp;

    always_comb
    begin
        error_sum_next     = error_sum_reg;
        last_error_next    = last_error_reg;
        heater_target_next = heater_target_reg;
        heater_drive_next  = heater_drive_reg;
        unique case (item.opcode)
            OP_OUTER:
            begin
                if (item.running)
                begin
                    last_error_next = err;
                    priority if (total[TOT_W-1])
                    begin
                        heater_target_next = '0;
                        error_sum_next     = sum_sat;
                    end
                    else if (over)
                    begin
                        // Overshoot: clamp and leave the sum where it was
                        heater_target_next = cfg.outer_limit;
                    end
                    else
                    begin
                        heater_target_next = outv[TGT_W-1:0];
                        error_sum_next     = sum_sat;
                    end
                end
            end
            OP_INNER:
            begin
                heater_drive_next = (item.running && hot) ? cfg.drive_limit : '0;
            end
        endcase
    end

    assign res_next.heater_target = heater_target_next;
    assign res_next.heater_drive  = heater_drive_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg     <= '0;
            last_error_reg    <= '0;
            heater_target_reg <= APP_TARGET_RST;
            heater_drive_reg  <= '0;
        end
        else if (step)
        begin
            error_sum_reg     <= error_sum_next;
            last_error_reg    <= last_error_next;
            heater_target_reg <= heater_target_next;
            heater_drive_reg  <= heater_drive_next;
        end
    end

endmodule

// ===== rtl/cascade_pid_bang_bang_heater.sv =====
// ----------------------------------------------------------------------------
// cascade_pid_bang_bang_heater: two-loop temperature controller
// Outer PID loop sets the heater target; inner bang-bang loop drives the heater.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one output transfer carrying the heater
// target and heater drive as they stand after that item. An item with opcode
// 0 (outer tick) runs one PID step on the chamber sample against app_target:
// the error sum saturates at 32 bits, the output is clamped to
// [0, outer_limit], and on an overshoot the sum is left unchanged. An item
// with opcode 1 (inner tick) sets the drive to drive_limit while the target
// is above the heater sample, else to 0. With running low, outer ticks change
// nothing and inner ticks force the drive to 0. Samples are signed Q8.8,
// setpoints and targets unsigned Q7.8, gains unsigned Q8.8. The block takes one
// item per clock while the output is taken: each item passes through the input
// register, where the PID math (three gain multiplies, one add tree, one clamp
// compare) runs, and then sits in the output register until taken; the input
// side keeps accepting while the output register is drained in the same cycle.
// Output valid rises once the item has moved from the input register into the
// output register. Write the configuration port only while the block is idle.
// ----------------------------------------------------------------------------
module cascade_pid_bang_bang_heater
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cphh_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] sample_temp, [16] running
    input  logic [cphh_pkg::IN_TUSER_W-1:0]    s_tuser,   // [0] opcode

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cphh_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [14:0] heater_target_out,
                                                          // [24:15] heater_drive_out

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cphh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cphh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cphh_pkg::*;

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  res_next;
    res_t  out_res_reg;
    logic  out_valid_reg;
    logic  advance;

    // Move the held item into the output register when that slot is free
    // or being drained in this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.opcode      <= opcode_t'(s_tuser[0]);
            in_item_reg.sample_temp <= signed'(s_tdata[TEMP_W-1:0]);
            in_item_reg.running     <= s_tdata[TEMP_W];
        end
    end

    cphh_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Loop state updates in the same cycle the item leaves the input register
    cphh_pid u_pid
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (in_item_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    // Output register: hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - TGT_W - DRIVE_W){1'b0}},
                       out_res_reg.heater_drive, out_res_reg.heater_target};

endmodule

// ===== sim/heater_ctrl_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heater_ctrl_checker: shadow controller and result check for the heater
// Watches the register channel and both stream sides, steps its own copy of
// the cascade controller for every input transfer and compares each output
// transfer field by field against the oldest predicted heater status.
// ----------------------------------------------------------------------------
module heater_ctrl_checker
    import cphh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [IN_TUSER_W-1:0]  s_tuser,

    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int                     mismatches,
    output int                     checked,
    output int                     pending
);

    localparam longint SUM_HI    = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_LO    = -SUM_HI - 1;
    localparam longint ITERM_CAP = longint'(1) <<< 61;

    cfg_t                        regs;
    logic signed [SUM_WIDTH-1:0] err_sum;
    logic signed [ERR_W-1:0]     last_err;
    logic [TGT_W-1:0]            heater_tgt;
    logic [DRIVE_W-1:0]          heater_drv;

    res_t                        heater_status_q[$];

    task automatic report(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t              tick;
        res_t               want;
        logic [TGT_W-1:0]   got_tgt;
        logic [DRIVE_W-1:0] got_drv;
        longint             err;
        longint             acc;
        longint             iprod;
        longint             total;
        longint             scaled;

        if (!rst_n)
        begin
            regs.app_target             = APP_TARGET_RST;
            regs.prop_gain              = PROP_GAIN_RST;
            regs.integ_gain_period      = INTEG_GAIN_RST;
            regs.deriv_gain_over_period = DERIV_GAIN_RST;
            regs.outer_limit            = OUTER_LIMIT_RST;
            regs.drive_limit            = DRIVE_LIMIT_RST;
            err_sum    = '0;
            last_err   = '0;
            heater_tgt = APP_TARGET_RST;
            heater_drv = '0;
            heater_status_q.delete();
            mismatches = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_APP_TARGET:  regs.app_target             = cfg_data[TGT_W-1:0];
                    CFG_PROP_GAIN:   regs.prop_gain              = cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN:  regs.integ_gain_period      = cfg_data[GAIN_W-1:0];
                    CFG_DERIV_GAIN:  regs.deriv_gain_over_period = cfg_data[GAIN_W-1:0];
                    CFG_OUTER_LIMIT: regs.outer_limit            = cfg_data[TGT_W-1:0];
                    CFG_DRIVE_LIMIT: regs.drive_limit            = cfg_data[DRIVE_W-1:0];
                    default: ;
                endcase
            end

            // Compare before predicting: an output never belongs to the item
            // taken in the same cycle.
            if (m_tvalid && m_tready)
            begin
                got_tgt = m_tdata[TGT_W-1:0];
                got_drv = m_tdata[TGT_W +: DRIVE_W];
                if (heater_status_q.size() == 0)
                begin
                    report($sformatf("output transfer with no item outstanding: tdata %h",
                                     m_tdata));
                end
                else
                begin
                    want = heater_status_q.pop_front();
                    checked++;
                    if (got_tgt !== want.heater_target)
                        report($sformatf("heater target: got %0d, expected %0d",
                                         got_tgt, want.heater_target));
                    if (got_drv !== want.heater_drive)
                        report($sformatf("heater drive: got %0d, expected %0d",
                                         got_drv, want.heater_drive));
                end
            end

            if (s_tvalid && s_tready)
            begin
                tick.opcode      = opcode_t'(s_tuser[0]);
                tick.sample_temp = s_tdata[TEMP_W-1:0];
                tick.running     = s_tdata[TEMP_W];

                if (tick.opcode == OP_OUTER)
                begin
                    if (tick.running)
                    begin
                        err = longint'(regs.app_target) - longint'($signed(tick.sample_temp));
                        acc = longint'(err_sum) + err;
                        if (acc > SUM_HI)
                            acc = SUM_HI;
                        if (acc < SUM_LO)
                            acc = SUM_LO;

                        iprod = longint'(regs.integ_gain_period) * acc;
                        if (iprod > ITERM_CAP)
                            iprod = ITERM_CAP;
                        if (iprod < -ITERM_CAP)
                            iprod = -ITERM_CAP;

                        total = longint'(regs.prop_gain) * err + iprod
                              + longint'(regs.deriv_gain_over_period)
                                * (err - longint'(last_err));
                        last_err = err[ERR_W-1:0];

                        if (total < 0)
                        begin
                            heater_tgt = '0;
                            err_sum    = acc[SUM_WIDTH-1:0];
                        end
                        else
                        begin
                            scaled = total >>> FRAC_BITS;
                            if (scaled > longint'(regs.outer_limit))
                            begin
                                // overshoot: clamp and leave the sum where it was
                                heater_tgt = regs.outer_limit;
                            end
                            else
                            begin
                                heater_tgt = scaled[TGT_W-1:0];
                                err_sum    = acc[SUM_WIDTH-1:0];
                            end
                        end
                    end
                end
                else
                begin
                    if (tick.running &&
                        longint'(heater_tgt) > longint'($signed(tick.sample_temp)))
                        heater_drv = regs.drive_limit;
                    else
                        heater_drv = '0;
                end

                want.heater_target = heater_tgt;
                want.heater_drive  = heater_drv;
                heater_status_q.push_back(want);
            end

            pending = heater_status_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the cascade heater controller
// Drives outer and inner control ticks through the input stream and register
// writes through the configuration channel, across several register settings
// and three idling regimes, and lets the checker beside the block compare
// every heater status that comes out.
// ----------------------------------------------------------------------------
module testbench;
    import cphh_pkg::*;

    // Far above the slowest legal run: ~1750 ticks, most of them under heavy
    // idling on one side.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          BURST_LEN   = 290;

    logic                   clk;
    logic                   rst_n;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [15:0] sample_temp, [16] running
    logic [IN_TUSER_W-1:0]  s_tuser;    // [0] opcode

    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [14:0] heater_target_out, [24:15] heater_drive_out

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     mismatches;
    int                     checked;
    int                     pending;

    int                     src_idle_pct;
    int                     sink_idle_pct;
    int                     setpoint;       // app_target as last written
    int                     items_sent;
    int                     settings_used;
    int unsigned            cycle_count = 0;

    cascade_pid_bang_bang_heater u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    heater_ctrl_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .checked    (checked),
        .pending    (pending)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stall at random with the current idling rate, one update per
    // falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // Hand one tick to the block. Enter and leave at a falling edge; valid
    // stays high on return so back-to-back transfers never drop it.
    task automatic send_item(input opcode_t op, input logic signed [TEMP_W-1:0] temp,
                             input logic run);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W - TEMP_W - 1){1'b0}}, run, temp};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // One register write; the channel is idle again on return.
    task automatic cfg_write(input cfg_idx_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_regs(input int app, input int kp, input int ki, input int kd,
                                input int lim, input int drv);
        cfg_write(CFG_APP_TARGET,  app);
        cfg_write(CFG_PROP_GAIN,   kp);
        cfg_write(CFG_INTEG_GAIN,  ki);
        cfg_write(CFG_DERIV_GAIN,  kd);
        cfg_write(CFG_OUTER_LIMIT, lim);
        cfg_write(CFG_DRIVE_LIMIT, drv);
        setpoint = app;
        settings_used++;
    endtask

    // Drop valid and hold until every expected status has come back; the
    // block is idle after that, so registers may be written.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Sample within +-spread of the chamber setpoint, clipped to Q8.8 range.
    function automatic logic signed [TEMP_W-1:0] temp_near(input int spread);
        int v;
        v = setpoint + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[TEMP_W-1:0];
    endfunction

    // Mostly samples that keep the loop in its working range, with some far
    // off and some fully random ones to hit clamping and odd bit patterns.
    task automatic random_burst(input int count);
        opcode_t                  op;
        logic signed [TEMP_W-1:0] temp;
        logic                     run;
        int                       pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            op   = ($urandom_range(0, 1) == 0) ? OP_OUTER : OP_INNER;
            run  = ($urandom_range(0, 99) < 88);
            if (pick < 6)
                temp = temp_near(768);
            else if (pick < 8)
                temp = temp_near(8192);
            else
                temp = TEMP_W'($urandom);
            send_item(op, temp, run);
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        src_idle_pct  = 29;
        sink_idle_pct = 86;
        setpoint      = int'(APP_TARGET_RST);
        items_sent    = 0;
        settings_used = 1;

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ticks at the reset settings (setpoint 37.5 C, target
        // starting at the setpoint, drive off).
        send_item(OP_INNER, 16'sh8000, 1'b0);   // paused inner tick forces drive off
        send_item(OP_INNER, 16'sh8000, 1'b1);   // coldest heater: drive on
        send_item(OP_INNER, 16'sd9600, 1'b1);   // sample equal to target: off
        send_item(OP_INNER, 16'sd9599, 1'b1);   // just below target: on
        send_item(OP_INNER, 16'sh7FFF, 1'b1);   // hottest heater: off
        send_item(OP_OUTER, 16'sh8000, 1'b0);   // paused outer tick changes nothing
        send_item(OP_OUTER, 16'sd9600, 1'b1);   // zero error, zero output
        send_item(OP_INNER, 16'sd0, 1'b1);      // target 0 not above 0
        send_item(OP_INNER, -16'sd1, 1'b1);     // target 0 above -1
        send_item(OP_OUTER, 16'sd9536, 1'b1);   // small error, output in range
        send_item(OP_OUTER, 16'sd9599, 1'b1);   // derivative pulls output negative
        send_item(OP_OUTER, 16'sh8000, 1'b1);   // overshoot: clamp, sum backed out
        send_item(OP_OUTER, 16'sh7FFF, 1'b1);   // large negative error
        send_item(OP_OUTER, 16'sd9500, 1'b1);   // fraction bits dropped
        send_item(OP_OUTER, 16'sh5555, 1'b1);
        send_item(OP_OUTER, 16'shAAAA, 1'b1);
        send_item(OP_INNER, 16'sh5555, 1'b1);
        send_item(OP_INNER, 16'shAAAA, 1'b1);
        send_item(OP_OUTER, 16'sd9600, 1'b1);
        send_item(OP_INNER, 16'sh7FFF, 1'b0);
        send_item(OP_OUTER, 16'sd9620, 1'b1);
        send_item(OP_INNER, 16'sh0100, 1'b1);

        // Sender idles lightly, receiver heavily.
        random_burst(BURST_LEN);
        drain();
        program_regs(12800, 1024, 16, 512, 25600, 512);
        random_burst(BURST_LEN);

        // Swap the idling sides; all-ones registers, then a small-gain set.
        drain();
        src_idle_pct  = 86;
        sink_idle_pct = 29;
        program_regs(32767, 65535, 65535, 65535, 32767, 1023);
        random_burst(BURST_LEN);
        drain();
        program_regs(0, 300, 3, 40, 4096, 1);
        random_burst(BURST_LEN);

        // No idling from here on.
        drain();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        program_regs($urandom_range(0, 32767), $urandom_range(0, 65535),
                     $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(0, 32767), $urandom_range(0, 1023));
        random_burst(BURST_LEN);
        drain();
        program_regs(6400, 0, 0, 65535, 0, 0);
        random_burst(BURST_LEN);

        drain();
        repeat (4)
            @(negedge clk);

        $display("Sent %0d control ticks over %0d register settings and three idling regimes,",
                 items_sent, settings_used);
        $display("with directed clamp and drive edge cases; %0d results compared.",
                 checked);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
